FILE: design/vade_pkg.sv
`timescale 1ns / 1ps
// Package for the voice activity ducking envelope core.
// Holds register indexes, fixed widths, sequencer states and the control bundle.
// Depends on nothing.
package vade_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int SAMPLE_FIELDS = 4;
    localparam int MAX_CHANNELS  = 4;
    localparam int CHAN_LIMIT    = (MAX_CHANNELS < SAMPLE_FIELDS) ? MAX_CHANNELS : SAMPLE_FIELDS;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int PROD_W        = 32;

    localparam logic [15:0] Q15_ONE    = 16'h8000;
    localparam logic [31:0] ROUND_HALF = 32'h0000_8000;
    localparam logic [31:0] ROUND_Q15  = 32'h0000_4000;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUCK_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SMOOTH,
        ST_GAIN,
        ST_FINISH
    } vade_state_t;

    typedef enum logic {
        OP_SMOOTH,
        OP_GAIN
    } vade_op_t;

    typedef struct packed {
        logic     in_ready;
        logic     mul_en;
        vade_op_t op;
        logic     act_load;
        logic     commit;
    } vade_ctrl_t;

endpackage

FILE: design/vade_peak.sv
`timescale 1ns / 1ps
// Frame peak detector: largest magnitude over the channels in use, compared with the threshold.
// Depends on vade_pkg.
module vade_peak
    import vade_pkg::*;
(
    input  logic signed [SAMPLE_W-1:0] sample_zero,
    input  logic signed [SAMPLE_W-1:0] sample_one,
    input  logic signed [SAMPLE_W-1:0] sample_two,
    input  logic signed [SAMPLE_W-1:0] sample_three,
    input  logic [2:0]                 channels,
    input  logic [15:0]                threshold,
    output logic                       voice
);

    logic [SAMPLE_W-1:0] samples [SAMPLE_FIELDS];
    logic [SAMPLE_W:0]   mags    [SAMPLE_FIELDS];
    logic [2:0]          used;
    logic [SAMPLE_W:0]   peak;

    assign samples[0] = sample_zero;
    assign samples[1] = sample_one;
    assign samples[2] = sample_two;
    assign samples[3] = sample_three;

    assign used = (channels > 3'(CHAN_LIMIT)) ? 3'(CHAN_LIMIT) : channels;

    always_comb
    begin
        for (int i = 0; i < SAMPLE_FIELDS; i++)
        begin
            mags[i] = samples[i][SAMPLE_W-1] ? (17'h1_0000 - {1'b0, samples[i]})
                                             : {1'b0, samples[i]};
        end
        peak = '0;
        for (int i = 0; i < SAMPLE_FIELDS; i++)
        begin
            if ((3'(i) < used) && (mags[i] > peak))
            begin
                peak = mags[i];
            end
        end
    end

    assign voice = peak > {1'b0, threshold};

endmodule

FILE: design/vade_mac.sv
`timescale 1ns / 1ps
// Shared multiply-add unit with a registered result, used for smoothing and for the gain.
// Depends on vade_pkg.
module vade_mac
    import vade_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [15:0]       op_a,
    input  logic [15:0]       op_b,
    input  logic [PROD_W-1:0] addend,
    output logic [PROD_W-1:0] result
);

    logic [PROD_W-1:0] result_reg;
    logic [PROD_W-1:0] result_next;

    assign result_next = (PROD_W'(op_a) * PROD_W'(op_b)) + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: design/vade_ctrl.sv
`timescale 1ns / 1ps
// Sequencer that steps one frame through the shared multiply-add unit.
// Depends on vade_pkg.
module vade_ctrl
    import vade_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_hold,
    output vade_ctrl_t ctrl
);

    vade_state_t state_reg;
    vade_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ctrl.in_ready = 1'b0;
        ctrl.mul_en   = 1'b0;
        ctrl.op       = OP_SMOOTH;
        ctrl.act_load = 1'b0;
        ctrl.commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.op     = OP_SMOOTH;
                state_next  = ST_GAIN;
            end
            ST_GAIN:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.op       = OP_GAIN;
                ctrl.act_load = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_hold)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/voice_activity_ducking_envelope_core.sv
`timescale 1ns / 1ps
// Top level of the voice activity ducking envelope core.
// Depends on vade_pkg, vade_peak, vade_mac and vade_ctrl.

// Each input beat is one voice frame; the core gives one result beat per frame carrying the
// frame index, the Q15 smoothed voice activity, the Q8.8 dB ducking gain and a keyframe flag.
// A frame is accepted in idle, where its peak is found, then makes two passes through the
// single shared 16 by 16 multiply-add unit (smoothing, then gain) and is committed to the
// output register from the finish state. The core is not ready again until it is back in
// idle, so it takes no new frame before the last one has been committed. A new frame is
// taken while a finished result still waits at the output, but its commit then waits until
// that result has been read. A frame marked last returns activity and both counters to zero
// after its result; configuration registers keep their values.
module voice_activity_ducking_envelope_core
    import vade_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [SAMPLE_W-1:0]   sample_zero,
    input  logic signed [SAMPLE_W-1:0]   sample_one,
    input  logic signed [SAMPLE_W-1:0]   sample_two,
    input  logic signed [SAMPLE_W-1:0]   sample_three,
    input  logic                         last_frame,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [31:0]                  frame_index,
    output logic [15:0]                  activity,
    output logic signed [15:0]           gain_db,
    output logic                         keyframe
);

    logic [2:0]         channels_reg;
    logic [15:0]        threshold_reg;
    logic [15:0]        attack_reg;
    logic [15:0]        release_reg;
    logic signed [15:0] duck_gain_reg;
    logic [15:0]        interval_reg;

    logic [15:0] act_reg;
    logic [31:0] frame_cnt_reg;
    logic [15:0] interval_cnt_reg;
    logic        voice_reg;
    logic        last_reg;

    logic        out_valid_reg;
    logic [31:0] frame_index_reg;
    logic [15:0] activity_reg;
    logic [15:0] gain_reg;
    logic        keyframe_reg;

    vade_ctrl_t  ctrl;
    logic        voice;
    logic        out_hold;
    logic        rising;
    logic [15:0] alpha;
    logic [15:0] gmag;
    logic [16:0] one_minus_alpha;
    logic [31:0] target_term;
    logic [15:0] act_new;
    logic [15:0] op_a;
    logic [15:0] op_b;
    logic [31:0] addend;
    logic [31:0] mac_result;
    logic [15:0] amag;
    logic [15:0] interval_eff;
    logic [15:0] interval_inc;
    logic [15:0] interval_cnt_next;

    vade_peak u_peak (
        .sample_zero  (sample_zero),
        .sample_one   (sample_one),
        .sample_two   (sample_two),
        .sample_three (sample_three),
        .channels     (channels_reg),
        .threshold    (threshold_reg),
        .voice        (voice)
    );

    vade_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_hold (out_hold),
        .ctrl     (ctrl)
    );

    vade_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (ctrl.mul_en),
        .op_a   (op_a),
        .op_b   (op_b),
        .addend (addend),
        .result (mac_result)
    );

    assign out_hold = out_valid_reg && !out_ready;
    assign in_ready = ctrl.in_ready;

    assign rising          = voice_reg && (act_reg < Q15_ONE);
    assign alpha           = rising ? attack_reg : release_reg;
    assign one_minus_alpha = 17'h1_0000 - {1'b0, alpha};
    assign target_term     = voice_reg ? {one_minus_alpha, 15'b0} : 32'd0;
    assign gmag            = duck_gain_reg[15] ? 16'(17'h1_0000 - {1'b0, duck_gain_reg}) : 16'd0;
    assign act_new         = (mac_result[31:16] > Q15_ONE) ? Q15_ONE : mac_result[31:16];

    always_comb
    begin
        if (ctrl.op == OP_SMOOTH)
        begin
            op_a   = alpha;
            op_b   = act_reg;
            addend = target_term + ROUND_HALF;
        end
        else
        begin
            op_a   = gmag;
            op_b   = act_new;
            addend = ROUND_Q15;
        end
    end

    assign amag              = mac_result[30:15];
    assign interval_eff      = (interval_reg == 16'd0) ? 16'd1 : interval_reg;
    assign interval_inc      = interval_cnt_reg + 16'd1;
    assign interval_cnt_next = (interval_inc >= interval_eff) ? 16'd0 : interval_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg  <= 3'd1;
            threshold_reg <= 16'd1024;
            attack_reg    <= 16'd0;
            release_reg   <= 16'd0;
            duck_gain_reg <= -16'sd3072;
            interval_reg  <= 16'd4800;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANNELS:  channels_reg  <= cfg_data[2:0];
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_ATTACK:    attack_reg    <= cfg_data;
                REG_RELEASE:   release_reg   <= cfg_data;
                REG_DUCK_GAIN: duck_gain_reg <= cfg_data;
                REG_INTERVAL:  interval_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg          <= '0;
            frame_cnt_reg    <= '0;
            interval_cnt_reg <= '0;
            voice_reg        <= 1'b0;
            last_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.in_ready && in_valid)
            begin
                voice_reg <= voice;
                last_reg  <= last_frame;
            end
            if (ctrl.act_load)
            begin
                act_reg <= act_new;
            end
            if (ctrl.commit)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    act_reg          <= '0;
                    frame_cnt_reg    <= '0;
                    interval_cnt_reg <= '0;
                end
                else
                begin
                    frame_cnt_reg    <= frame_cnt_reg + 32'd1;
                    interval_cnt_reg <= interval_cnt_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            frame_index_reg <= frame_cnt_reg;
            activity_reg    <= act_reg;
            gain_reg        <= 16'd0 - amag;
            keyframe_reg    <= (interval_cnt_reg == 16'd0) || last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_index = frame_index_reg;
    assign activity    = activity_reg;
    assign gain_db     = gain_reg;
    assign keyframe    = keyframe_reg;

endmodule
